### src/pl2d_pkg.sv
// ----------------------------------------------------------------------------
// pl2d_pkg
// shared types and constants of the 2d pooling forward unit
// ----------------------------------------------------------------------------
`default_nettype none

package pl2d_pkg;

	localparam int PX_W   = 16;
	localparam int POS_W  = 9;
	localparam int K_W    = 5;
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 10;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_KERNEL,
		REG_STRIDE,
		REG_HEIGHT,
		REG_WIDTH
	} reg_idx_t;

	typedef struct packed {
		logic             mode;
		logic [K_W-1:0]   k;
		logic [K_W-1:0]   s;
		logic [POS_W-1:0] h;
		logic [POS_W-1:0] w;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] q;
		logic [K_W-1:0]   rem;
	} qr_t;

	typedef struct packed {
		logic signed [PX_W-1:0] px;
		logic [POS_W-1:0]       r;
		logic [POS_W-1:0]       c;
		logic [POS_W-1:0]       jlo;
		logic [POS_W-1:0]       jhi;
		logic [POS_W-1:0]       ilo;
		logic [POS_W-1:0]       ihi;
	} task_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ADDR,
		B_UPD,
		B_DIV,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

### src/pl2d_front.sv
// ----------------------------------------------------------------------------
// pl2d_front
// tracks the pixel position and the range of windows covering each pixel
// ----------------------------------------------------------------------------
`default_nettype none

module pl2d_front import pl2d_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   cfg_wr,
	input  wire logic signed [PX_W-1:0] pixel,
	input  wire logic                   pixel_valid,
	output logic                        pixel_stall,
	input  wire logic                   q_full,
	output logic                        push,
	output task_t                       push_task
);

	logic [POS_W-1:0] r_q, c_q, r_nx, c_nx;
	qr_t rhi_q, rlo_q, chi_q, clo_q;
	logic accept, c_wrap, r_wrap;

	function automatic qr_t qr_step(qr_t cur, logic [K_W-1:0] s);
		qr_t res;
		if ((cur.rem + K_W'(1)) == s) begin
			res.q   = cur.q + POS_W'(1);
			res.rem = '0;
		end else begin
			res.q   = cur.q;
			res.rem = cur.rem + K_W'(1);
		end
		return res;
	endfunction

	function automatic qr_t lo_step(logic [POS_W-1:0] pos, logic [K_W-1:0] k,
			logic [K_W-1:0] s, qr_t cur);
		qr_t res;
		res = '0;
		if (pos == POS_W'(k)) begin
			res.q = POS_W'(1);
		end else if (pos > POS_W'(k)) begin
			res = qr_step(cur, s);
		end
		return res;
	endfunction

	assign accept      = pixel_valid && !q_full;
	assign pixel_stall = q_full;
	assign c_wrap      = ({1'b0, c_q} + (POS_W+1)'(1)) == {1'b0, cfg.w};
	assign r_wrap      = ({1'b0, r_q} + (POS_W+1)'(1)) == {1'b0, cfg.h};
	assign c_nx        = c_wrap ? '0 : c_q + POS_W'(1);
	assign r_nx        = r_wrap ? '0 : r_q + POS_W'(1);

	always_comb begin
		push_task.px  = pixel;
		push_task.r   = r_q;
		push_task.c   = c_q;
		push_task.jlo = rlo_q.q;
		push_task.jhi = rhi_q.q;
		push_task.ilo = clo_q.q;
		push_task.ihi = chi_q.q;
		push = accept && (rlo_q.q <= rhi_q.q) && (clo_q.q <= chi_q.q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			c_q   <= '0;
			rhi_q <= '0;
			rlo_q <= '0;
			chi_q <= '0;
			clo_q <= '0;
		end else if (cfg_wr) begin
			r_q   <= '0;
			c_q   <= '0;
			rhi_q <= '0;
			rlo_q <= '0;
			chi_q <= '0;
			clo_q <= '0;
		end else if (accept) begin
			c_q <= c_nx;
			if (c_wrap) begin
				chi_q <= '0;
				clo_q <= '0;
				r_q   <= r_nx;
				if (r_wrap) begin
					rhi_q <= '0;
					rlo_q <= '0;
				end else begin
					rhi_q <= qr_step(rhi_q, cfg.s);
					rlo_q <= lo_step(r_nx, cfg.k, cfg.s, rlo_q);
				end
			end else begin
				chi_q <= qr_step(chi_q, cfg.s);
				clo_q <= lo_step(c_nx, cfg.k, cfg.s, clo_q);
			end
		end
	end

endmodule

`default_nettype wire

### src/pl2d_queue.sv
// ----------------------------------------------------------------------------
// pl2d_queue
// short task queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module pl2d_queue import pl2d_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire task_t push_task,
	input  wire logic  pop,
	output task_t      head,
	output logic       full,
	output logic       empty
);

	task_t               entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     count_q;

	assign full  = count_q == (QPTR_W+1)'(QDEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_task;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/pl2d_back.sv
// ----------------------------------------------------------------------------
// pl2d_back
// walks the windows of each pixel, updates the accumulators, divides (average mode), emits
// ----------------------------------------------------------------------------
`default_nettype none

module pl2d_back import pl2d_pkg::*; #(
	parameter int ACC_W = 24,
	parameter int KB    = 4,
	parameter int WB    = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              q_empty,
	input  wire task_t             head,
	output logic                   pop,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic signed [PX_W-1:0] pooled_value,
	output logic [IDX_W-1:0]       out_row,
	output logic [IDX_W-1:0]       out_col,
	output logic                   last_of_plane
);

	localparam int DEPTH = 2 ** (KB + WB);
	localparam int STP_W = $clog2(ACC_W + 1);
	localparam int E_W   = POS_W + 2;

	back_state_t state_q, state_nx;
	task_t tk_q;
	logic [POS_W-1:0] j_q, i_q, hs_q, ws_q;
	logic [ACC_W-1:0] mem [DEPTH];
	logic [ACC_W-1:0] rd_q, dvd_q;
	logic [KB+WB-1:0] addr;
	logic [PX_W-1:0]  val_q;
	logic             last_q, neg_q;
	logic [CNT_W-1:0] dvs_q, rem_q;
	logic [STP_W-1:0] step_q;
	logic [POS_W+K_W-1:0] hs_prod, ws_prod;

	logic signed [ACC_W-1:0] acc_new, rd_s, px_e;
	logic [E_W-1:0] hs_e, ws_e, k_e, s_e, h_e, w_e, he, we;
	logic [K_W-1:0] rh, cw;
	logic [CNT_W-1:0] cnt;
	logic win_ok, first, fin, last, last_iter;
	logic [CNT_W:0] rem_sh;
	logic           qbit;
	logic [PX_W-1:0] quot;

	logic do_adv, do_load, do_div_init;

	assign addr = {j_q[KB-1:0], i_q[WB-1:0]};
	assign hs_prod = {{K_W{1'b0}}, j_q} * {{POS_W{1'b0}}, cfg.s};
	assign ws_prod = {{K_W{1'b0}}, i_q} * {{POS_W{1'b0}}, cfg.s};

	always_comb begin
		hs_e = E_W'(hs_q);
		ws_e = E_W'(ws_q);
		k_e  = E_W'(cfg.k);
		s_e  = E_W'(cfg.s);
		h_e  = E_W'(cfg.h);
		w_e  = E_W'(cfg.w);
		he   = (hs_e + k_e < h_e) ? hs_e + k_e : h_e;
		we   = (ws_e + k_e < w_e) ? ws_e + k_e : w_e;
		win_ok = ((j_q == '0) || (hs_e + k_e < h_e + s_e))
			&& ((i_q == '0) || (ws_e + k_e < w_e + s_e));
		first = (tk_q.r == hs_q) && (tk_q.c == ws_q);
		fin   = (E_W'(tk_q.r) + E_W'(1) == he) && (E_W'(tk_q.c) + E_W'(1) == we);
		last  = ((hs_e + s_e >= h_e) || (hs_e + k_e >= h_e))
			&& ((ws_e + s_e >= w_e) || (ws_e + k_e >= w_e));
		rh    = K_W'(he - hs_e);
		cw    = K_W'(we - ws_e);
		cnt   = CNT_W'({{K_W{1'b0}}, rh} * {{K_W{1'b0}}, cw});
		rd_s  = rd_q;
		px_e  = ACC_W'(tk_q.px);
		if (first) begin
			acc_new = px_e;
		end else if (cfg.mode) begin
			acc_new = rd_s + px_e;
		end else begin
			acc_new = (px_e > rd_s) ? px_e : rd_s;
		end
		last_iter = (j_q == tk_q.jhi) && (i_q == tk_q.ihi);
		rem_sh = {rem_q, dvd_q[ACC_W-1]};
		qbit   = rem_sh >= {1'b0, dvs_q};
		quot   = neg_q ? PX_W'(-dvd_q[PX_W-1:0]) : dvd_q[PX_W-1:0];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_IDLE: if (!q_empty) state_nx = B_ADDR;
			B_ADDR: state_nx = B_UPD;
			B_UPD: begin
				if (win_ok && fin) begin
					state_nx = cfg.mode ? B_DIV : B_EMIT;
				end else begin
					state_nx = last_iter ? B_IDLE : B_ADDR;
				end
			end
			B_DIV: if (step_q == '0) state_nx = B_EMIT;
			B_EMIT: begin
				if (!result_valid || !result_stall) begin
					state_nx = last_iter ? B_IDLE : B_ADDR;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop         = 1'b0;
		do_adv      = 1'b0;
		do_load     = 1'b0;
		do_div_init = 1'b0;
		unique case (state_q)
			B_IDLE: pop = !q_empty;
			B_ADDR: ;
			B_UPD: begin
				do_div_init = 1'b1;
				do_adv      = !(win_ok && fin);
			end
			B_DIV: ;
			B_EMIT: begin
				do_load = !result_valid || !result_stall;
				do_adv  = do_load;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (do_load) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_ADDR) begin
			rd_q <= mem[addr];
		end
		if (state_q == B_UPD && win_ok) begin
			mem[addr] <= acc_new;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tk_q <= head;
			j_q  <= head.jlo;
			i_q  <= head.ilo;
		end
		if (state_q == B_ADDR) begin
			hs_q <= POS_W'(hs_prod);
			ws_q <= POS_W'(ws_prod);
		end
		if (do_div_init) begin
			val_q  <= acc_new[PX_W-1:0];
			last_q <= last;
			neg_q  <= acc_new[ACC_W-1];
			dvd_q  <= acc_new[ACC_W-1] ? ACC_W'(-acc_new) : acc_new;
			dvs_q  <= cnt;
			rem_q  <= '0;
			step_q <= STP_W'(ACC_W);
		end
		if (state_q == B_DIV && step_q != '0) begin
			dvd_q  <= {dvd_q[ACC_W-2:0], qbit};
			rem_q  <= qbit ? CNT_W'(rem_sh - {1'b0, dvs_q}) : CNT_W'(rem_sh);
			step_q <= step_q - STP_W'(1);
		end
		if (do_adv) begin
			if (i_q == tk_q.ihi) begin
				i_q <= tk_q.ilo;
				j_q <= j_q + POS_W'(1);
			end else begin
				i_q <= i_q + POS_W'(1);
			end
		end
		if (do_load) begin
			pooled_value  <= cfg.mode ? quot : val_q;
			out_row       <= j_q[IDX_W-1:0];
			out_col       <= i_q[IDX_W-1:0];
			last_of_plane <= last_q;
		end
	end

endmodule

`default_nettype wire

### src/pooling_2d_forward_unit.sv
// ----------------------------------------------------------------------------
// pooling_2d_forward_unit
// streaming 2d max / average pooling over signed q8.8 feature planes
//
// pixels enter in raster order on pixel / pixel_valid / pixel_stall, plane
// after plane; pooled values leave on result_valid / result_stall with their
// row, column and an end-of-plane flag. a transaction happens on a clock edge
// with valid high and stall low. the user writes registers over the apb port
// only while the unit is idle, which the block itself does not enforce; a write
// to any of the five registers restarts the plane position. the front takes one
// pixel per cycle, unless the queue is full, into a four-entry task queue. for
// each covering window the back does a read then a write on the single
// accumulator memory port. a finished average window goes through a serial
// divide with one step per accumulator bit, then into the output register.
// when the receiver stalls the result holds, the back waits and the queue fills,
// after which pixel_stall rises.
// reset restores the register defaults and the plane position; accumulator
// contents need no clearing since each window is loaded by its first pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module pooling_2d_forward_unit import pl2d_pkg::*; #(
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_KERNEL = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]           prdata,
	output logic                        pready,
	input  wire logic signed [PX_W-1:0] pixel,
	input  wire logic                   pixel_valid,
	output logic                        pixel_stall,
	output logic signed [PX_W-1:0]      pooled_value,
	output logic [IDX_W-1:0]            out_row,
	output logic [IDX_W-1:0]            out_col,
	output logic                        last_of_plane,
	output logic                        result_valid,
	input  wire logic                   result_stall
);

	localparam int KB     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int WB_RAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WB     = (WB_RAW > POS_W) ? POS_W : WB_RAW;
	localparam int ACC_W  = PX_W + $clog2(MAX_KERNEL * MAX_KERNEL);
	localparam int CMP_W  = 14;

	logic             mode_q;
	logic [K_W-1:0]   k_q, s_q;
	logic [POS_W-1:0] h_q, w_q;
	cfg_t             cfg;
	reg_idx_t         idx;
	logic             wr, cfg_wr, push, pop, q_full, q_empty;
	task_t            push_task, head;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;

	always_comb begin
		cfg_wr = 1'b0;
		prdata = '0;
		unique case (idx)
			REG_MODE: begin
				cfg_wr = wr;
				prdata = DATA_W'(mode_q);
			end
			REG_KERNEL: begin
				cfg_wr = wr;
				prdata = DATA_W'(k_q);
			end
			REG_STRIDE: begin
				cfg_wr = wr;
				prdata = DATA_W'(s_q);
			end
			REG_HEIGHT: begin
				cfg_wr = wr;
				prdata = DATA_W'(h_q);
			end
			REG_WIDTH: begin
				cfg_wr = wr;
				prdata = DATA_W'(w_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			k_q    <= K_W'(2);
			s_q    <= K_W'(2);
			h_q    <= POS_W'(256);
			w_q    <= POS_W'(256);
		end else if (wr) begin
			unique case (idx)
				REG_MODE:   mode_q <= pwdata[0];
				REG_KERNEL: k_q    <= pwdata[K_W-1:0];
				REG_STRIDE: s_q    <= pwdata[K_W-1:0];
				REG_HEIGHT: h_q    <= pwdata[POS_W-1:0];
				REG_WIDTH:  w_q    <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// zero counts as one, larger values saturate
	always_comb begin
		cfg.mode = mode_q;
		if (k_q == '0) cfg.k = K_W'(1);
		else if (CMP_W'(k_q) > CMP_W'(MAX_KERNEL)) cfg.k = K_W'(MAX_KERNEL);
		else cfg.k = k_q;
		if (s_q == '0) cfg.s = K_W'(1);
		else if (CMP_W'(s_q) > CMP_W'(MAX_KERNEL)) cfg.s = K_W'(MAX_KERNEL);
		else cfg.s = s_q;
		if (h_q == '0) cfg.h = POS_W'(1);
		else if (CMP_W'(h_q) > CMP_W'(MAX_HEIGHT)) cfg.h = POS_W'(MAX_HEIGHT);
		else cfg.h = h_q;
		if (w_q == '0) cfg.w = POS_W'(1);
		else if (CMP_W'(w_q) > CMP_W'(MAX_WIDTH)) cfg.w = POS_W'(MAX_WIDTH);
		else cfg.w = w_q;
	end

	pl2d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cfg_wr      (cfg_wr),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.q_full      (q_full),
		.push        (push),
		.push_task   (push_task)
	);

	pl2d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_task (push_task),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	pl2d_back #(
		.ACC_W (ACC_W),
		.KB    (KB),
		.WB    (WB)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_empty       (q_empty),
		.head          (head),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.pooled_value  (pooled_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.last_of_plane (last_of_plane)
	);

endmodule

`default_nettype wire

### src/pl2d_checker.sv
// ----------------------------------------------------------------------------
// pl2d_checker
// port-level checks of the 2d pooling forward unit
// ----------------------------------------------------------------------------
`default_nettype none

module pl2d_checker import pl2d_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   pready,
	input wire logic                   result_valid,
	input wire logic                   result_stall,
	input wire logic signed [PX_W-1:0] pooled_value,
	input wire logic                   last_of_plane
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_ready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("stalled transaction dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(pooled_value) && $stable(last_of_plane))
		else $error("stalled transaction changed");

endmodule

bind pooling_2d_forward_unit pl2d_checker u_pl2d_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pready        (pready),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.pooled_value  (pooled_value),
	.last_of_plane (last_of_plane)
);

`default_nettype wire

### test/tb_pooling_2d_forward_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pooling_2d_forward_unit
// self-checking bench for the streaming 2d pooling forward unit
//
// pixels are pushed in raster order under several window setups, max and
// average, and each pooled transaction is checked field by field against a
// window predictor kept inside a small scoreboard class. both sides idle in
// random bursts; one long output hold-off fills the unit, and pauses on the
// input side drain it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pooling_2d_forward_unit;
	import pl2d_pkg::*;

	localparam int KMAX  = 16;
	localparam int HMAX  = 256;
	localparam int WMAX  = 256;
	localparam int WDOG  = 20000;
	localparam int DRAIN = 3000;

	typedef struct {
		logic signed [15:0] value;
		logic [7:0]         row;
		logic [7:0]         col;
		logic               last;
	} pooled_t;

	class pool_scoreboard;
		logic        mode;
		logic [4:0]  k_reg, s_reg;
		logic [8:0]  h_reg, w_reg;
		int          row_pos, col_pos;
		int          acc [KMAX*WMAX];
		pooled_t     pending [$];
		int          errors;
		int          checked;

		function new();
			mode = 0; k_reg = 2; s_reg = 2; h_reg = 256; w_reg = 256;
			row_pos = 0; col_pos = 0; errors = 0; checked = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_MODE:   mode  = v[0];
				REG_KERNEL: k_reg = v[4:0];
				REG_STRIDE: s_reg = v[4:0];
				REG_HEIGHT: h_reg = v[8:0];
				REG_WIDTH:  w_reg = v[8:0];
				default: ;
			endcase
			row_pos = 0;
			col_pos = 0;
		endfunction

		function int clampv(int v, int hi);
			if (v == 0) return 1;
			return v > hi ? hi : v;
		endfunction

		function int windows(int d, int k, int s);
			int n, cap;
			if (d <= k) return 1;
			n = (d - k + s - 1) / s + 1;
			cap = (d + s - 1) / s;
			return n < cap ? n : cap;
		endfunction

		function void note_pixel(logic signed [15:0] px);
			int k, s, h, w, nr, nc, r, c, jlo, jhi, ilo, ihi;
			int hs, he, ws, we, idx, a;
			pooled_t p;
			k = clampv(k_reg, KMAX); s = clampv(s_reg, KMAX);
			h = clampv(h_reg, HMAX); w = clampv(w_reg, WMAX);
			nr = windows(h, k, s); nc = windows(w, k, s);
			r = row_pos; c = col_pos;
			if (r >= h) r = 0;
			if (c >= w) c = 0;
			jlo = (r >= k) ? (r - k) / s + 1 : 0;
			jhi = r / s; if (jhi > nr - 1) jhi = nr - 1;
			ilo = (c >= k) ? (c - k) / s + 1 : 0;
			ihi = c / s; if (ihi > nc - 1) ihi = nc - 1;
			for (int j = jlo; j <= jhi && j < nr; j++) begin
				hs = j * s;
				he = (hs + k < h) ? hs + k : h;
				for (int i = ilo; i <= ihi && i < nc; i++) begin
					ws = i * s;
					we = (ws + k < w) ? ws + k : w;
					idx = ((j % KMAX) * WMAX + i) % (KMAX * WMAX);
					if (r == hs && c == ws) a = px;
					else begin
						a = acc[idx];
						if (mode) a += px;
						else if (px > a) a = px;
					end
					acc[idx] = a;
					if (r == he - 1 && c == we - 1) begin
						if (mode) a = a / ((he - hs) * (we - ws));
						p.value = a[15:0];
						p.row = j[7:0];
						p.col = i[7:0];
						p.last = (j == nr - 1 && i == nc - 1);
						pending.push_back(p);
					end
				end
			end
			c++;
			if (c >= w) begin
				c = 0; r++;
				if (r >= h) r = 0;
			end
			row_pos = r; col_pos = c;
		endfunction

		function void check_result(pooled_t got);
			pooled_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected transaction value %0d row %0d col %0d", $time,
					got.value, got.row, got.col);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.value !== e.value) begin
				$display("%0t: pooled_value exp %0d got %0d", $time, e.value, got.value);
				errors++;
			end
			if (got.row !== e.row) begin
				$display("%0t: out_row exp %0d got %0d", $time, e.row, got.row);
				errors++;
			end
			if (got.col !== e.col) begin
				$display("%0t: out_col exp %0d got %0d", $time, e.col, got.col);
				errors++;
			end
			if (got.last !== e.last) begin
				$display("%0t: last_of_plane exp %0d got %0d", $time, e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic pready;
	logic signed [PX_W-1:0] pixel;
	logic pixel_valid, pixel_stall;
	logic signed [PX_W-1:0] pooled_value;
	logic [IDX_W-1:0] out_row, out_col;
	logic last_of_plane, result_valid, result_stall;

	pooling_2d_forward_unit u_dut (.*);

	pool_scoreboard sb;
	bit  calm;
	bit  hold_off;
	int  idle_cycles;
	int  sent;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			pooled_t got;
			got.value = pooled_value;
			got.row = out_row;
			got.col = out_col;
			got.last = last_of_plane;
			sb.check_result(got);
		end
	end

	// receiver side stall bursts
	initial begin
		int n;
		result_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				result_stall <= 1;
				repeat (400) @(negedge clk);
				result_stall <= 0;
				hold_off = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 18);
				result_stall <= 1;
				repeat (n) @(negedge clk);
				result_stall <= 0;
			end
		end
	end

	task automatic apb_write(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(4 * int'(idx)); pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.write_reg(idx, v);
	endtask

	task automatic send_pixel(logic signed [15:0] v);
		int n;
		if (!calm && $urandom_range(0, 6) == 0) begin
			pixel_valid <= 0;
			n = $urandom_range(1, 18);
			repeat (n) @(negedge clk);
		end
		pixel <= v;
		pixel_valid <= 1;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		sb.note_pixel(v);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		pixel_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_px();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic setup(int m, int k, int s, int h, int w);
		drain();
		apb_write(REG_MODE, m);
		apb_write(REG_KERNEL, k);
		apb_write(REG_STRIDE, s);
		apb_write(REG_HEIGHT, h);
		apb_write(REG_WIDTH, w);
	endtask

	task automatic run_planes(int planes);
		int cnt;
		cnt = sb.clampv(sb.h_reg, HMAX) * sb.clampv(sb.w_reg, WMAX) * planes;
		for (int i = 0; i < cnt; i++) send_pixel(rand_px());
	endtask

	initial begin
		int m, k, s, h, w;
		sb = new();
		calm = 0; hold_off = 0; sent = 0; idle_cycles = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		pixel = '0; pixel_valid = 0;
		arst_n = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;

		// directed: extremes and special cases
		setup(0, 2, 2, 2, 2);
		send_pixel(16'sh8000); send_pixel(16'sh7fff); send_pixel(-16'sd1); send_pixel(0);
		setup(1, 2, 2, 2, 2);
		send_pixel(16'sh7fff); send_pixel(16'sh7fff); send_pixel(16'sh7fff);
		send_pixel(16'sh7fff);
		setup(1, 0, 0, 0, 0);
		send_pixel(16'sh8000); send_pixel(-16'sd3);
		setup(1, 31, 31, 3, 3);
		run_planes(1);
		setup(0, 1, 5, 3, 4);
		run_planes(1);
		setup(1, 3, 2, 256, 2);
		hold_off = 1;
		run_planes(1);
		drain();

		// random configurations, mostly small planes
		while (sent < 1700) begin
			m = $urandom_range(0, 1);
			k = $urandom_range(0, 20);
			s = $urandom_range(0, 20);
			h = $urandom_range(0, 12);
			w = $urandom_range(0, 12);
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(250, 300);
				h = $urandom_range(0, 1);
			end
			if (sent > 1400) calm = 1;
			setup(m, k, s, h, w);
			run_planes($urandom_range(1, 3));
			if ($urandom_range(0, 4) == 0)
				for (int i = 0; i < $urandom_range(1, 7); i++) send_pixel(rand_px());
		end
		drain();

		$display("pixels sent %0d, pooled transactions checked %0d", sent, sb.checked);
		$display("modes max and average, kernel and stride 0..20, planes 0..300 wide");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
